// File: rtl/dmsc_pkg.sv
// ----------------------------------------------------------------------------
// dmsc_pkg
// Shared types, codes and helpers of the drive mode safety controller.
// ----------------------------------------------------------------------------
package dmsc_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int TIME_W  = 32;
    localparam int DIST_W  = 16;
    localparam int SPEED_W = 15;
    localparam int OUT_W   = 16;
    localparam int MODE_W  = 2;
    localparam int ACT_W   = 2;
    localparam int CAUSE_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Approach-speed divider: product of cruise speed and distance offset
    localparam int NUM_W  = SPEED_W + DIST_W;
    localparam int DEN_W  = DIST_W;
    localparam int QUOT_W = SPEED_W;
    localparam int CNT_W  = $clog2(QUOT_W);

    // Signed working width for corner speeds before saturation
    localparam int WORK_W = SPEED_W + 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STOP_DIST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DIST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE    = 3'd5;

    // Configuration reset values
    localparam logic [DIST_W-1:0]  RST_STOP_DIST = 16'd320;
    localparam logic [DIST_W-1:0]  RST_SLOW_DIST = 16'd960;
    localparam logic [SPEED_W-1:0] RST_CRUISE    = 15'd200;
    localparam logic [SPEED_W-1:0] RST_TURN      = 15'd150;
    localparam logic [SPEED_W-1:0] RST_LIMIT     = 15'd255;
    localparam logic [TIME_W-1:0]  RST_MAX_AGE   = 32'd100;

    // Commands
    localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_MODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

    // Drive modes
    localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AVOID = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DEMO  = 2'd3;

    // Motor actions
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STOP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DRIVE = 2'd2;

    // Fault causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_STALE   = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_BATTERY = 2'd2;

    // Saturate a signed speed at plus or minus lim
    function automatic logic [OUT_W-1:0] clamp_speed(
        input logic signed [WORK_W-1:0] v,
        input logic        [SPEED_W-1:0] lim
    );
        logic signed [WORK_W-1:0] lim_s;
        logic signed [WORK_W-1:0] res;
        lim_s = signed'({{(WORK_W-SPEED_W){1'b0}}, lim});
        if (v > lim_s) begin
            res = lim_s;
        end else if (v < -lim_s) begin
            res = -lim_s;
        end else begin
            res = v;
        end
        return res[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/dmsc_cmd_if.sv
// ----------------------------------------------------------------------------
// dmsc_cmd_if
// Command channel: one command item per transfer.
// ----------------------------------------------------------------------------
interface dmsc_cmd_if
    import dmsc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [TIME_W-1:0]  now_ms;
    logic [TIME_W-1:0]  sample_time_ms;
    logic [DIST_W-1:0]  distance;
    logic               distance_ok;
    logic               battery_ok;
    logic               battery_low;
    logic               line_on_left;
    logic               line_on_right;
    logic [MODE_W-1:0]  new_mode;

    modport source (
        output valid, command, now_ms, sample_time_ms, distance, distance_ok,
               battery_ok, battery_low, line_on_left, line_on_right, new_mode,
        input  ready
    );

    modport sink (
        input  valid, command, now_ms, sample_time_ms, distance, distance_ok,
               battery_ok, battery_low, line_on_left, line_on_right, new_mode,
        output ready
    );
endinterface

// File: rtl/dmsc_res_if.sv
// ----------------------------------------------------------------------------
// dmsc_res_if
// Result channel: motor command, corner speeds and controller status.
// ----------------------------------------------------------------------------
interface dmsc_res_if
    import dmsc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         motor_action;
    logic signed [OUT_W-1:0]  front_left_speed;
    logic signed [OUT_W-1:0]  rear_left_speed;
    logic signed [OUT_W-1:0]  front_right_speed;
    logic signed [OUT_W-1:0]  rear_right_speed;
    logic                     fault_latched;
    logic [CAUSE_W-1:0]       fault_cause;
    logic [MODE_W-1:0]        current_mode;

    modport source (
        output valid, motor_action, front_left_speed, rear_left_speed,
               front_right_speed, rear_right_speed, fault_latched, fault_cause,
               current_mode,
        input  ready
    );

    modport sink (
        input  valid, motor_action, front_left_speed, rear_left_speed,
               front_right_speed, rear_right_speed, fault_latched, fault_cause,
               current_mode,
        output ready
    );
endinterface

// File: rtl/dmsc_divider.sv
// ----------------------------------------------------------------------------
// dmsc_divider
// Serial restoring divider, one quotient bit per cycle. The caller
// guarantees the quotient fits QUOT_W bits (numerator < den << QUOT_W).
// ----------------------------------------------------------------------------
module dmsc_divider
    import dmsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    logic [DEN_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_q;
    logic [DEN_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    // Trial subtract: partial remainder with the next numerator bit shifted in
    logic [DEN_W:0]    shifted;
    logic [DEN_W+1:0]  trial;

    assign shifted = {r_rem, r_q[QUOT_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_den};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits enter r_q from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NUM_W-1:QUOT_W];
            r_q   <= i_num[QUOT_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            if (!trial[DEN_W+1]) begin
                r_rem <= trial[DEN_W-1:0];
                r_q   <= {r_q[QUOT_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DEN_W-1:0];
                r_q   <= {r_q[QUOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: rtl/drive_mode_safety_controller.sv
// ----------------------------------------------------------------------------
// drive_mode_safety_controller
// Mode and fault keeper for a four-corner drive; turns each command into one
// motor result.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives exactly one result. Mode changes,
// fault clears, ignored commands and samples that stop or need no distance
// scaling pass through the transfer cycle, a check state and a final state;
// the result register loads as the final state is left. A sample that passes
// the safety checks and whose distance lies strictly between the stop and
// slow distances also runs a multiply state, a divider start state and the
// 15-step serial divider for the approach speed. The command channel is
// ready only while the sequencer is idle; a finished result waits in the
// output register, so the next command can be taken before it is
// collected. The final cycle of that next command stalls for as long as
// the previous result is still waiting. Configuration writes are meant for
// idle periods.
// ----------------------------------------------------------------------------
module drive_mode_safety_controller
    import dmsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dmsc_cmd_if.sink              i_cmd,
    dmsc_res_if.source            o_res
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_DSTART = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_FINAL  = 7'b0100000,
        S_SPARE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Configuration
    logic [DIST_W-1:0]  r_stop_dist;
    logic [DIST_W-1:0]  r_slow_dist;
    logic [SPEED_W-1:0] r_cruise;
    logic [SPEED_W-1:0] r_turn;
    logic [SPEED_W-1:0] r_limit;
    logic [TIME_W-1:0]  r_max_age;

    // Controller state
    logic [MODE_W-1:0]  r_mode;
    logic               r_fault;
    logic [CAUSE_W-1:0] r_cause;

    // Captured command
    logic [CMD_W-1:0]   r_cmd;
    logic [TIME_W-1:0]  r_now;
    logic [TIME_W-1:0]  r_ts;
    logic [DIST_W-1:0]  r_dist;
    logic               r_dok;
    logic               r_bok;
    logic               r_blow;
    logic               r_left;
    logic               r_right;
    logic [MODE_W-1:0]  r_nmode;

    // Work registers
    logic [ACT_W-1:0]   r_act;
    logic               r_d_le_stop;
    logic [DIST_W-1:0]  r_diff;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_prod;
    logic [SPEED_W-1:0] r_fwd;

    // Result register
    logic               r_out_valid;
    logic [ACT_W-1:0]   r_out_act;
    logic [OUT_W-1:0]   r_out_fl;
    logic [OUT_W-1:0]   r_out_rl;
    logic [OUT_W-1:0]   r_out_fr;
    logic [OUT_W-1:0]   r_out_rr;
    logic               r_out_fault;
    logic [CAUSE_W-1:0] r_out_cause;
    logic [MODE_W-1:0]  r_out_mode;

    logic               cmd_xfer;
    logic               res_xfer;
    logic               out_free;
    logic               div_start;
    logic               div_done;
    logic [QUOT_W-1:0]  div_quot;

    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;
    assign res_xfer    = o_res.valid && o_res.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign div_start   = (r_state == S_DSTART);

    // Serial divider for the approach speed
    dmsc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_dist <= RST_STOP_DIST;
            r_slow_dist <= RST_SLOW_DIST;
            r_cruise    <= RST_CRUISE;
            r_turn      <= RST_TURN;
            r_limit     <= RST_LIMIT;
            r_max_age   <= RST_MAX_AGE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STOP_DIST: r_stop_dist <= i_cfg_data[DIST_W-1:0];
                REG_SLOW_DIST: r_slow_dist <= i_cfg_data[DIST_W-1:0];
                REG_CRUISE:    r_cruise    <= i_cfg_data[SPEED_W-1:0];
                REG_TURN:      r_turn      <= i_cfg_data[SPEED_W-1:0];
                REG_LIMIT:     r_limit     <= i_cfg_data[SPEED_W-1:0];
                REG_MAX_AGE:   r_max_age   <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Command capture
    always_ff @(posedge i_clk) begin
        if (cmd_xfer) begin
            r_cmd   <= i_cmd.command;
            r_now   <= i_cmd.now_ms;
            r_ts    <= i_cmd.sample_time_ms;
            r_dist  <= i_cmd.distance;
            r_dok   <= i_cmd.distance_ok;
            r_bok   <= i_cmd.battery_ok;
            r_blow  <= i_cmd.battery_low;
            r_left  <= i_cmd.line_on_left;
            r_right <= i_cmd.line_on_right;
            r_nmode <= i_cmd.new_mode;
        end
    end

    // Check stage: sample age, battery, mode and distance bands
    logic [TIME_W-1:0] age;
    logic              stale;
    logic              d_le_stop;
    logic              d_ge_slow;

    assign age       = r_now - r_ts;
    assign stale     = age > r_max_age;
    assign d_le_stop = r_dist <= r_stop_dist;
    assign d_ge_slow = r_dist >= r_slow_dist;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (cmd_xfer) n_state = S_CHECK;
            S_CHECK: begin
                if (r_cmd == CMD_SAMPLE && !r_fault && !stale && !(r_bok && r_blow)
                    && r_mode != MODE_IDLE && r_dok && !d_le_stop && !d_ge_slow) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_MUL:    n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV:    if (div_done) n_state = S_FINAL;
            S_FINAL:  if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Controller state and decision
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_fault <= 1'b0;
            r_cause <= CAUSE_NONE;
        end else if (r_state == S_CHECK) begin
            priority if (r_cmd == CMD_SAMPLE) begin
                if (!r_fault && stale) begin
                    r_fault <= 1'b1;
                    r_cause <= CAUSE_STALE;
                end else if (!r_fault && r_bok && r_blow) begin
                    r_fault <= 1'b1;
                    r_cause <= CAUSE_BATTERY;
                end
            end else if (r_cmd == CMD_SET_MODE) begin
                r_mode <= r_nmode;
            end else if (r_cmd == CMD_CLEAR) begin
                r_fault <= 1'b0;
                r_cause <= CAUSE_NONE;
                r_mode  <= MODE_IDLE;
            end else begin
                // unknown command: state holds
            end
        end
    end

    // Work registers: decided action, distance offset, forward speed
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_CHECK: begin
                r_d_le_stop <= d_le_stop;
                r_diff      <= r_dist - r_stop_dist;
                r_den       <= r_slow_dist - r_stop_dist;
                r_fwd       <= d_le_stop ? '0 : r_cruise;
                priority if (r_cmd == CMD_SAMPLE) begin
                    if (r_fault || stale || (r_bok && r_blow)
                        || r_mode == MODE_IDLE || !r_dok) begin
                        r_act <= ACT_STOP;
                    end else begin
                        r_act <= ACT_DRIVE;
                    end
                end else if (r_cmd == CMD_SET_MODE) begin
                    r_act <= (r_nmode != r_mode) ? ACT_STOP : ACT_NONE;
                end else if (r_cmd == CMD_CLEAR) begin
                    r_act <= ACT_STOP;
                end else begin
                    r_act <= ACT_NONE;
                end
            end
            S_MUL:   r_prod <= NUM_W'(r_cruise) * NUM_W'(r_diff);
            S_DIV:   if (div_done) r_fwd <= div_quot;
            default: ;
        endcase
    end

    // Final stage: corner speeds for the current mode, then saturation
    logic signed [WORK_W-1:0] fwd_s;
    logic signed [WORK_W-1:0] turn_s;
    logic signed [WORK_W-1:0] half_s;
    logic signed [WORK_W-1:0] three_q_s;
    logic signed [WORK_W-1:0] raw_fl, raw_rl, raw_fr, raw_rr;
    logic [ACT_W-1:0]         fin_act;
    logic                     fwd_zero;

    assign fwd_s     = signed'({{(WORK_W-SPEED_W){1'b0}}, r_fwd});
    assign turn_s    = signed'({{(WORK_W-SPEED_W){1'b0}}, r_turn});
    assign half_s    = turn_s >>> 1;
    assign three_q_s = ((fwd_s <<< 1) + fwd_s) >>> 2;
    assign fwd_zero  = (r_fwd == '0);

    always_comb begin
        fin_act = r_act;
        raw_fl  = '0;
        raw_rl  = '0;
        raw_fr  = '0;
        raw_rr  = '0;
        if (r_act == ACT_DRIVE) begin
            unique case (r_mode)
                MODE_LINE: begin
                    if (fwd_zero) begin
                        fin_act = ACT_STOP;
                    end else if (r_left && r_right) begin
                        raw_fl = fwd_s;
                        raw_rl = fwd_s;
                        raw_fr = fwd_s;
                        raw_rr = fwd_s;
                    end else if (r_left) begin
                        raw_fl = half_s;
                        raw_rl = half_s;
                        raw_fr = turn_s;
                        raw_rr = turn_s;
                    end else if (r_right) begin
                        raw_fl = turn_s;
                        raw_rl = turn_s;
                        raw_fr = half_s;
                        raw_rr = half_s;
                    end else begin
                        fin_act = ACT_STOP;
                    end
                end
                MODE_AVOID: begin
                    if (r_d_le_stop) begin
                        raw_fl = turn_s;
                        raw_rl = turn_s;
                        raw_fr = -turn_s;
                        raw_rr = -turn_s;
                    end else begin
                        raw_fl = fwd_s;
                        raw_rl = fwd_s;
                        raw_fr = fwd_s;
                        raw_rr = fwd_s;
                    end
                end
                MODE_DEMO: begin
                    if (fwd_zero) begin
                        fin_act = ACT_STOP;
                    end else begin
                        raw_fl = fwd_s;
                        raw_rl = three_q_s;
                        raw_fr = fwd_s;
                        raw_rr = three_q_s;
                    end
                end
                MODE_IDLE: fin_act = ACT_STOP;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FINAL && out_free) begin
            r_out_valid <= 1'b1;
        end else if (res_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINAL && out_free) begin
            r_out_act <= fin_act;
            r_out_fl  <= clamp_speed(raw_fl, r_limit);
            r_out_rl  <= clamp_speed(raw_rl, r_limit);
            r_out_fr  <= clamp_speed(raw_fr, r_limit);
            r_out_rr  <= clamp_speed(raw_rr, r_limit);
        end
    end

    // Status fields are captured with the result, after the check stage has
    // updated the controller state
    always_ff @(posedge i_clk) begin
        if (r_state == S_FINAL && out_free) begin
            r_out_fault <= r_fault;
            r_out_cause <= r_cause;
            r_out_mode  <= r_mode;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.motor_action      = r_out_act;
    assign o_res.front_left_speed  = signed'(r_out_fl);
    assign o_res.rear_left_speed   = signed'(r_out_rl);
    assign o_res.front_right_speed = signed'(r_out_fr);
    assign o_res.rear_right_speed  = signed'(r_out_rr);
    assign o_res.fault_latched     = r_out_fault;
    assign o_res.fault_cause       = r_out_cause;
    assign o_res.current_mode      = r_out_mode;

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the drive mode safety controller. Commands are sent
// through a randomly idling driver, every result is compared field by field
// against an in-bench prediction of mode, fault latch and corner speeds, and
// the run steps through several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb
    import dmsc_pkg::*;
;

    // Command code that the block must ignore
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] sample_time_ms;
        logic [DIST_W-1:0] distance;
        logic              distance_ok;
        logic              battery_ok;
        logic              battery_low;
        logic              line_on_left;
        logic              line_on_right;
        logic [MODE_W-1:0] new_mode;
    } t_drive_cmd;

    typedef struct {
        logic [ACT_W-1:0]        motor_action;
        logic signed [OUT_W-1:0] fl;
        logic signed [OUT_W-1:0] rl;
        logic signed [OUT_W-1:0] fr;
        logic signed [OUT_W-1:0] rr;
        logic                    fault_latched;
        logic [CAUSE_W-1:0]      fault_cause;
        logic [MODE_W-1:0]       current_mode;
    } t_motor_res;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    dmsc_cmd_if cmd_ch ();
    dmsc_res_if res_ch ();

    drive_mode_safety_controller u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch)
    );

    // Register copies seen by the prediction
    logic [DIST_W-1:0]  stop_cfg    = RST_STOP_DIST;
    logic [DIST_W-1:0]  slow_cfg    = RST_SLOW_DIST;
    logic [SPEED_W-1:0] cruise_cfg  = RST_CRUISE;
    logic [SPEED_W-1:0] turn_cfg    = RST_TURN;
    logic [SPEED_W-1:0] limit_cfg   = RST_LIMIT;
    logic [TIME_W-1:0]  max_age_cfg = RST_MAX_AGE;

    // Controller state as predicted
    logic [MODE_W-1:0]  mode_q  = MODE_IDLE;
    logic               fault_q = 1'b0;
    logic [CAUSE_W-1:0] cause_q = CAUSE_NONE;

    t_drive_cmd pending_cmds[$];
    t_motor_res due_responses[$];

    t_drive_cmd drv_item;
    int         drv_gap     = 0;
    int         hold_left   = 0;
    int         idle_pct    = 30;
    int         rx_count    = 0;
    int         fail_cnt    = 0;
    int         quiet_count = 0;

    // Clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic signed [OUT_W-1:0] sat_speed(int v);
        int lim;
        lim = int'(limit_cfg);
        if (v > lim) v = lim;
        else if (v < -lim) v = -lim;
        return v[OUT_W-1:0];
    endfunction

    // Linear ramp of cruise speed between stop and slow distance, truncated
    function automatic int approach_speed(logic [DIST_W-1:0] d);
        longint unsigned num;
        longint unsigned den;
        if (d <= stop_cfg) return 0;
        if (d >= slow_cfg) return int'(cruise_cfg);
        num = 64'(cruise_cfg) * 64'(d - stop_cfg);
        den = 64'(slow_cfg - stop_cfg);
        return int'(num / den);
    endfunction

    function automatic t_motor_res driven(int fl, int rl, int fr, int rr);
        t_motor_res r;
        r = '{default: '0};
        r.motor_action = ACT_DRIVE;
        r.fl = sat_speed(fl);
        r.rl = sat_speed(rl);
        r.fr = sat_speed(fr);
        r.rr = sat_speed(rr);
        return r;
    endfunction

    // Expected result of one command; advances the predicted state
    function automatic t_motor_res motor_response(t_drive_cmd c);
        t_motor_res        r;
        logic [TIME_W-1:0] age;
        int                fwd;
        int                trn;
        r = '{default: '0};
        r.motor_action = ACT_NONE;
        trn = int'(turn_cfg);
        age = c.now_ms - c.sample_time_ms;
        case (c.command)
            CMD_SAMPLE: begin
                if (fault_q) begin
                    r.motor_action = ACT_STOP;
                end else if (age > max_age_cfg) begin
                    r.motor_action = ACT_STOP;
                    fault_q = 1'b1;
                    cause_q = CAUSE_STALE;
                end else if (c.battery_ok && c.battery_low) begin
                    r.motor_action = ACT_STOP;
                    fault_q = 1'b1;
                    cause_q = CAUSE_BATTERY;
                end else if (mode_q == MODE_IDLE || !c.distance_ok) begin
                    r.motor_action = ACT_STOP;
                end else if (mode_q == MODE_LINE) begin
                    fwd = approach_speed(c.distance);
                    if (fwd == 0) r.motor_action = ACT_STOP;
                    else if (c.line_on_left && c.line_on_right) r = driven(fwd, fwd, fwd, fwd);
                    else if (c.line_on_left) r = driven(trn / 2, trn / 2, trn, trn);
                    else if (c.line_on_right) r = driven(trn, trn, trn / 2, trn / 2);
                    else r.motor_action = ACT_STOP;
                end else if (mode_q == MODE_AVOID) begin
                    // pivot when too close, otherwise forward even at zero
                    if (c.distance <= stop_cfg) begin
                        r = driven(trn, trn, -trn, -trn);
                    end else begin
                        fwd = approach_speed(c.distance);
                        r = driven(fwd, fwd, fwd, fwd);
                    end
                end else begin
                    fwd = approach_speed(c.distance);
                    if (fwd == 0) r.motor_action = ACT_STOP;
                    else r = driven(fwd, fwd * 3 / 4, fwd, fwd * 3 / 4);
                end
            end
            CMD_SET_MODE: begin
                if (c.new_mode != mode_q) r.motor_action = ACT_STOP;
                mode_q = c.new_mode;
            end
            CMD_CLEAR: begin
                r.motor_action = ACT_STOP;
                fault_q = 1'b0;
                cause_q = CAUSE_NONE;
                mode_q  = MODE_IDLE;
            end
            default: ;
        endcase
        r.fault_latched = fault_q;
        r.fault_cause   = cause_q;
        r.current_mode  = mode_q;
        return r;
    endfunction

    function automatic string fmt_res(t_motor_res r);
        return $sformatf("act=%0d fl=%0d rl=%0d fr=%0d rr=%0d flt=%0b cause=%0d mode=%0d",
                         r.motor_action, r.fl, r.rl, r.fr, r.rr,
                         r.fault_latched, r.fault_cause, r.current_mode);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly short gaps, a few long ones; none when idling is off
    function automatic int pick_gap();
        if ($urandom_range(99) >= idle_pct) return 0;
        if ($urandom_range(99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_drive_cmd rand_cmd();
        t_drive_cmd c;
        c.command        = CMD_W'($urandom);
        c.now_ms         = $urandom;
        c.sample_time_ms = $urandom;
        c.distance       = DIST_W'($urandom);
        c.distance_ok    = 1'($urandom_range(0, 1));
        c.battery_ok     = 1'($urandom_range(0, 1));
        c.battery_low    = 1'($urandom_range(0, 1));
        c.line_on_left   = 1'($urandom_range(0, 1));
        c.line_on_right  = 1'($urandom_range(0, 1));
        c.new_mode       = MODE_W'($urandom);
        return c;
    endfunction

    // Sample age that passes the staleness check, often right at the limit
    function automatic logic [TIME_W-1:0] fresh_age();
        if ($urandom_range(0, 4) == 0) return max_age_cfg;
        if (max_age_cfg > 1000 && $urandom_range(0, 1)) return $urandom_range(1000);
        return $urandom_range(max_age_cfg);
    endfunction

    function automatic logic [TIME_W-1:0] stale_age();
        if (max_age_cfg == '1) return fresh_age();
        if ($urandom_range(0, 1)) return max_age_cfg + 32'd1;
        return $urandom_range(32'hFFFF_FFFF, max_age_cfg + 32'd1);
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance();
        logic [DIST_W-1:0] lo;
        logic [DIST_W-1:0] hi;
        lo = (stop_cfg < slow_cfg) ? stop_cfg : slow_cfg;
        hi = (stop_cfg < slow_cfg) ? slow_cfg : stop_cfg;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return stop_cfg;
            3: return stop_cfg + 1'b1;
            4: return slow_cfg - 1'b1;
            5: return slow_cfg;
            6: return DIST_W'($urandom);
            default: return DIST_W'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic t_drive_cmd sample_cmd(logic [DIST_W-1:0] d, bit dok, bit bok,
                                              bit blow, bit l, bit r);
        t_drive_cmd c;
        c = rand_cmd();
        c.command        = CMD_SAMPLE;
        c.sample_time_ms = c.now_ms - fresh_age();
        c.distance       = d;
        c.distance_ok    = dok;
        c.battery_ok     = bok;
        c.battery_low    = blow;
        c.line_on_left   = l;
        c.line_on_right  = r;
        return c;
    endfunction

    // Sample that gets past the safety checks unless distance is invalid
    function automatic t_drive_cmd clean_sample();
        bit bok;
        bok = 1'($urandom_range(0, 1));
        return sample_cmd(pick_distance(), $urandom_range(0, 9) != 0, bok,
                          bok ? 1'b0 : 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic t_drive_cmd mode_cmd(logic [MODE_W-1:0] m);
        t_drive_cmd c;
        c = rand_cmd();
        c.command  = CMD_SET_MODE;
        c.new_mode = m;
        return c;
    endfunction

    function automatic t_drive_cmd coded_cmd(logic [CMD_W-1:0] code);
        t_drive_cmd c;
        c = rand_cmd();
        c.command = code;
        return c;
    endfunction

    // Mostly mode + sample runs; some faults with recovery, some noise
    task automatic queue_random_traffic(int n);
        int         made;
        int         pick;
        t_drive_cmd c;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                if ($urandom_range(0, 2) == 0) begin
                    pending_cmds.push_back(coded_cmd(CMD_CLEAR));
                    made++;
                end
                pending_cmds.push_back(mode_cmd(MODE_W'($urandom_range(1, 3))));
                made++;
                repeat ($urandom_range(4, 16)) begin
                    pending_cmds.push_back(clean_sample());
                    made++;
                end
            end else if (pick < 77) begin
                c = clean_sample();
                if ($urandom_range(0, 1)) begin
                    c.sample_time_ms = c.now_ms - stale_age();
                end else begin
                    c.battery_ok  = 1'b1;
                    c.battery_low = 1'b1;
                end
                pending_cmds.push_back(c);
                made++;
                repeat ($urandom_range(0, 3)) begin
                    pending_cmds.push_back(($urandom_range(0, 1)) ? clean_sample()
                                                  : mode_cmd(MODE_W'($urandom)));
                    made++;
                end
                pending_cmds.push_back(coded_cmd(CMD_CLEAR));
                made++;
            end else if (pick < 87) begin
                pending_cmds.push_back(mode_cmd(MODE_W'($urandom)));
                made++;
            end else begin
                pending_cmds.push_back(rand_cmd());
                made++;
                if ($urandom_range(0, 9) < 7) begin
                    pending_cmds.push_back(coded_cmd(CMD_CLEAR));
                    made++;
                end
            end
        end
    endtask

    // Register write, mirrored into the prediction
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_STOP_DIST: stop_cfg    = data[DIST_W-1:0];
            REG_SLOW_DIST: slow_cfg    = data[DIST_W-1:0];
            REG_CRUISE:    cruise_cfg  = data[SPEED_W-1:0];
            REG_TURN:      turn_cfg    = data[SPEED_W-1:0];
            REG_LIMIT:     limit_cfg   = data[SPEED_W-1:0];
            REG_MAX_AGE:   max_age_cfg = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_settings(logic [DIST_W-1:0] stop_d, logic [DIST_W-1:0] slow_d,
                                 logic [SPEED_W-1:0] cruise, logic [SPEED_W-1:0] turn,
                                 logic [SPEED_W-1:0] limit, logic [TIME_W-1:0] max_age);
        cfg_write(REG_STOP_DIST, CFG_DATA_W'(stop_d));
        cfg_write(REG_SLOW_DIST, CFG_DATA_W'(slow_d));
        cfg_write(REG_CRUISE, CFG_DATA_W'(cruise));
        cfg_write(REG_TURN, CFG_DATA_W'(turn));
        cfg_write(REG_LIMIT, CFG_DATA_W'(limit));
        cfg_write(REG_MAX_AGE, max_age);
    endtask

    // Wait until every queued command is sent and every result is back
    task automatic drain();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || cmd_ch.valid || due_responses.size() != 0);
        repeat (30) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            drv_gap = 0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                due_responses.push_back(motor_response(drv_item));
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    cmd_ch.valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    drv_item = pending_cmds.pop_front();
                    cmd_ch.command        <= drv_item.command;
                    cmd_ch.now_ms         <= drv_item.now_ms;
                    cmd_ch.sample_time_ms <= drv_item.sample_time_ms;
                    cmd_ch.distance       <= drv_item.distance;
                    cmd_ch.distance_ok    <= drv_item.distance_ok;
                    cmd_ch.battery_ok     <= drv_item.battery_ok;
                    cmd_ch.battery_low    <= drv_item.battery_low;
                    cmd_ch.line_on_left   <= drv_item.line_on_left;
                    cmd_ch.line_on_right  <= drv_item.line_on_right;
                    cmd_ch.new_mode       <= drv_item.new_mode;
                    cmd_ch.valid          <= 1'b1;
                    drv_gap = pick_gap();
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver back-pressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_motor_res got;
        t_motor_res exp_r;
        int         g;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got.motor_action  = res_ch.motor_action;
                got.fl            = res_ch.front_left_speed;
                got.rl            = res_ch.rear_left_speed;
                got.fr            = res_ch.front_right_speed;
                got.rr            = res_ch.rear_right_speed;
                got.fault_latched = res_ch.fault_latched;
                got.fault_cause   = res_ch.fault_cause;
                got.current_mode  = res_ch.current_mode;
                if (due_responses.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected result: %s", $realtime, fmt_res(got));
                end else begin
                    exp_r = due_responses.pop_front();
                    if (got.motor_action !== exp_r.motor_action || got.fl !== exp_r.fl ||
                        got.rl !== exp_r.rl || got.fr !== exp_r.fr || got.rr !== exp_r.rr ||
                        got.fault_latched !== exp_r.fault_latched ||
                        got.fault_cause !== exp_r.fault_cause ||
                        got.current_mode !== exp_r.current_mode) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS)
                            $display("%0t: result %0d mismatch\n  expected %s\n  actual   %s",
                                     $realtime, rx_count, fmt_res(exp_r), fmt_res(got));
                    end
                end
                rx_count++;
                // long hold-off so the block backs up and stalls its input
                if (rx_count == 100 || rx_count == 1000) hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                g = pick_gap();
                if (g > 0) hold_left = g - 1;
                res_ch.ready <= (g == 0);
            end
        end
    end

    // Watchdog: too long without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_count = 0;
        end else begin
            quiet_count++;
            if (quiet_count >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        cmd_ch.valid          = 1'b0;
        cmd_ch.command        = CMD_SAMPLE;
        cmd_ch.now_ms         = '0;
        cmd_ch.sample_time_ms = '0;
        cmd_ch.distance       = '0;
        cmd_ch.distance_ok    = 1'b0;
        cmd_ch.battery_ok     = 1'b0;
        cmd_ch.battery_low    = 1'b0;
        cmd_ch.line_on_left   = 1'b0;
        cmd_ch.line_on_right  = 1'b0;
        cmd_ch.new_mode       = MODE_IDLE;
        res_ch.ready          = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with reset register values
        // idle mode stops
        pending_cmds.push_back(sample_cmd(16'd2000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
        pending_cmds.push_back(mode_cmd(MODE_LINE));
        pending_cmds.push_back(mode_cmd(MODE_LINE));                  // same mode: no command
        // both sensors, left only, right only, line lost
        pending_cmds.push_back(sample_cmd(16'd2000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
        pending_cmds.push_back(sample_cmd(16'd2000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
        pending_cmds.push_back(sample_cmd(16'd2000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
        pending_cmds.push_back(sample_cmd(16'd2000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        // ramp truncated, at stop distance, invalid distance, low flag w/o valid read
        pending_cmds.push_back(sample_cmd(16'd500, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
        pending_cmds.push_back(sample_cmd(16'd320, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
        pending_cmds.push_back(sample_cmd(16'd2000, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1));
        pending_cmds.push_back(sample_cmd(16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
        // age at limit, time wraps
        drv_item = sample_cmd(16'd700, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
        drv_item.now_ms         = 32'd5;
        drv_item.sample_time_ms = 32'd5 - max_age_cfg;
        pending_cmds.push_back(drv_item);
        pending_cmds.push_back(mode_cmd(MODE_AVOID));
        // pivot, forward at zero, far
        pending_cmds.push_back(sample_cmd(16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        pending_cmds.push_back(sample_cmd(16'd321, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        pending_cmds.push_back(sample_cmd(16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        pending_cmds.push_back(mode_cmd(MODE_DEMO));
        pending_cmds.push_back(sample_cmd(16'd959, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        pending_cmds.push_back(sample_cmd(16'd2000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        // just past max age
        drv_item = sample_cmd(16'd2000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        drv_item.sample_time_ms = drv_item.now_ms - (max_age_cfg + 32'd1);
        pending_cmds.push_back(drv_item);
        // while latched
        pending_cmds.push_back(sample_cmd(16'd2000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
        pending_cmds.push_back(mode_cmd(MODE_LINE));                  // mode change while latched
        pending_cmds.push_back(coded_cmd(CMD_CLEAR));
        // critical battery
        pending_cmds.push_back(sample_cmd(16'd2000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        pending_cmds.push_back(coded_cmd(CMD_CLEAR));
        pending_cmds.push_back(coded_cmd(CMD_IGNORED));
        drain();

        // Random phases over several register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_settings(16'd0, 16'hFFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF);
                1: load_settings(16'hFFFF, 16'd0, 15'd0, 15'd0, 15'd0, 32'd0);
                2: load_settings(16'd100, 16'd400, 15'd30000, 15'd30001, 15'd50, 32'd1000);
                default: load_settings(DIST_W'($urandom_range(3000)),
                                       DIST_W'($urandom_range(6000)),
                                       SPEED_W'($urandom), SPEED_W'($urandom),
                                       SPEED_W'($urandom),
                                       ($urandom_range(0, 3) == 0) ? $urandom
                                                                   : $urandom_range(2000));
            endcase
            idle_pct = (ph == 4) ? 0 : ((ph == 6) ? 70 : 25);
            queue_random_traffic(190);
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
